### rtl/core/mpsm_pkg.sv
// shared types and constants for the multi-pattern substring matcher
// used by mpsm_front, mpsm_back and the top level
package mpsm_pkg;

	localparam int NODE_W     = 8;
	localparam int MAX_NODES  = 256;
	localparam int GOTO_AW    = NODE_W + 8;
	localparam int GOTO_DEPTH = MAX_NODES * 256;
	localparam int MASK_W     = 32;

	localparam logic [2:0] FN_CLEAR = 3'd0;
	localparam logic [2:0] FN_PAT   = 3'd1;
	localparam logic [2:0] FN_END   = 3'd2;
	localparam logic [2:0] FN_BUILD = 3'd3;
	localparam logic [2:0] FN_TEXT  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVF     = 2'd1;
	localparam logic [1:0] ST_UNBUILT = 2'd2;

	typedef enum logic [2:0] {
		K_CLR = 3'd0,
		K_PAT = 3'd1,
		K_END = 3'd2,
		K_BLD = 3'd3,
		K_TXT = 3'd4,
		K_NOP = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [4:0] pattern_slot;
		logic       first;
		logic       last;
	} cmd_t;

endpackage

### rtl/core/mpsm_front.sv
// front end: accepts items, decodes func into a command kind, two-entry queue
// depends on mpsm_pkg
module mpsm_front import mpsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] func,
	input  logic [7:0] data_byte,
	input  logic [4:0] pattern_slot,
	input  logic       first,
	input  logic       last,
	output logic       q_valid,
	output cmd_t       q_cmd,
	input  logic       q_pop
);

	cmd_t       ent_q [0:1];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_in;
	kind_t      kind;

	always_comb begin
		case (func)
			FN_CLEAR: kind = K_CLR;
			FN_PAT:   kind = K_PAT;
			FN_END:   kind = K_END;
			FN_BUILD: kind = K_BLD;
			FN_TEXT:  kind = K_TXT;
			default:  kind = K_NOP;
		endcase
	end

	assign cmd_in     = '{kind: kind, data_byte: data_byte, pattern_slot: pattern_slot,
		first: first, last: last};
	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign q_valid    = (cnt_q != 2'd0);
	assign q_cmd      = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

endmodule

### rtl/core/mpsm_back.sv
// back end: sequencer over the goto, failure, mask and bfs memories
// plus the result register; depends on mpsm_pkg
module mpsm_back import mpsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [1:0]        status,
	output logic [MASK_W-1:0] node_mask,
	output logic [MASK_W-1:0] seen_mask,
	output logic              any_match,
	output logic              end_of_text
);

	typedef enum logic [24:0] {
		S_CLR   = 25'd1 << 0,
		S_IDLE  = 25'd1 << 1,
		S_PB_RD = 25'd1 << 2,
		S_PB_EV = 25'd1 << 3,
		S_EP_RD = 25'd1 << 4,
		S_EP_WR = 25'd1 << 5,
		S_T0    = 25'd1 << 6,
		S_T1    = 25'd1 << 7,
		S_TG    = 25'd1 << 8,
		S_TE    = 25'd1 << 9,
		S_TF    = 25'd1 << 10,
		S_TM    = 25'd1 << 11,
		S_OUT   = 25'd1 << 12,
		S_B_R0  = 25'd1 << 13,
		S_B_R1  = 25'd1 << 14,
		S_B_H   = 25'd1 << 15,
		S_B_U   = 25'd1 << 16,
		S_B_UF  = 25'd1 << 17,
		S_B_C0  = 25'd1 << 18,
		S_B_C1  = 25'd1 << 19,
		S_B_W0  = 25'd1 << 20,
		S_B_W1  = 25'd1 << 21,
		S_B_W2  = 25'd1 << 22,
		S_B_M1  = 25'd1 << 23,
		S_B_M2  = 25'd1 << 24
	} state_t;

	logic [NODE_W-1:0] goto_mem [0:GOTO_DEPTH-1];
	logic [NODE_W-1:0] fail_mem [0:MAX_NODES-1];
	logic [MASK_W-1:0] mask_mem [0:MAX_NODES-1];
	logic [NODE_W-1:0] bfs_mem  [0:MAX_NODES-1];

	logic [GOTO_AW-1:0] g_ra, g_wa;
	logic [NODE_W-1:0]  g_wd, g_rd_q;
	logic               g_we;
	logic [NODE_W-1:0]  f_ra, f_wa, f_wd, f_rd_q;
	logic               f_we;
	logic [NODE_W-1:0]  m_ra, m_wa;
	logic [MASK_W-1:0]  m_wd, m_rd_q;
	logic               m_we;
	logic [NODE_W-1:0]  b_ra, b_wa, b_wd, b_rd_q;
	logic               b_we;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [GOTO_AW-1:0] cnt_q;
	logic               emit_q;
	logic [NODE_W:0]    ncount_q, head_q, tail_q;
	logic [NODE_W-1:0]  cur_q, mnode_q, u_q, fu_q, node_q, v_q;
	logic [7:0]         c_q;
	logic               built_q, ov_q;
	logic [MASK_W-1:0]  run_q, mt_q;
	logic [MASK_W-1:0]  res_nm_q, res_seen_q;
	logic               res_unb_q, res_eot_q;
	logic               out_free;

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (g_we) goto_mem[g_wa] <= g_wd;
		g_rd_q <= goto_mem[g_ra];
	end
	always_ff @(posedge clk) begin
		if (f_we) fail_mem[f_wa] <= f_wd;
		f_rd_q <= fail_mem[f_ra];
	end
	always_ff @(posedge clk) begin
		if (m_we) mask_mem[m_wa] <= m_wd;
		m_rd_q <= mask_mem[m_ra];
	end
	always_ff @(posedge clk) begin
		if (b_we) bfs_mem[b_wa] <= b_wd;
		b_rd_q <= bfs_mem[b_ra];
	end

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign out_free = !result_valid || !result_stall;

	always_comb begin
		g_ra = {node_q, c_q};
		g_wa = {cur_q, cmd_q.data_byte};
		g_wd = ncount_q[NODE_W-1:0];
		g_we = 1'b0;
		f_ra = node_q;
		f_wa = v_q;
		f_wd = g_rd_q;
		f_we = 1'b0;
		m_ra = v_q;
		m_wa = v_q;
		m_wd = m_rd_q | mt_q;
		m_we = 1'b0;
		b_ra = head_q[NODE_W-1:0];
		b_wa = tail_q[NODE_W-1:0];
		b_wd = g_rd_q;
		b_we = 1'b0;
		case (state_q)
			S_CLR: begin
				g_we = 1'b1;
				g_wa = cnt_q;
				g_wd = '0;
				m_we = (cnt_q[GOTO_AW-1:NODE_W] == '0);
				m_wa = cnt_q[NODE_W-1:0];
				m_wd = '0;
			end
			S_PB_RD: g_ra = {cur_q, cmd_q.data_byte};
			S_PB_EV: begin
				if (g_rd_q == '0 && !ncount_q[NODE_W]) begin
					g_we = 1'b1;
					m_we = 1'b1;
					m_wa = ncount_q[NODE_W-1:0];
					m_wd = '0;
				end
			end
			S_EP_RD: m_ra = cur_q;
			S_EP_WR: begin
				m_we = 1'b1;
				m_wa = cur_q;
				m_wd = m_rd_q | (MASK_W'(1) << cmd_q.pattern_slot);
			end
			S_T0: m_ra = '0;
			S_TG: g_ra = {mnode_q, cmd_q.data_byte};
			S_TE: begin
				f_ra = mnode_q;
				m_ra = g_rd_q;
			end
			S_B_R0: g_ra = {{NODE_W{1'b0}}, c_q};
			S_B_R1: begin
				if (g_rd_q != '0) begin
					f_we = 1'b1;
					f_wa = g_rd_q;
					f_wd = '0;
					b_we = !tail_q[NODE_W];
				end
			end
			S_B_U: f_ra = b_rd_q;
			S_B_C0: g_ra = {u_q, c_q};
			S_B_C1: b_we = (g_rd_q != '0) && !tail_q[NODE_W];
			S_B_W1: begin
				m_ra = g_rd_q;
				// fall-back walk ends here: the edge read is the link target
				f_we = !(node_q != '0 && g_rd_q == '0);
			end
			S_B_M2: m_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					cmd_q      <= q_cmd;
					res_nm_q   <= '0;
					res_seen_q <= '0;
					res_unb_q  <= 1'b0;
					res_eot_q  <= (q_cmd.kind == K_TXT) && q_cmd.last;
					c_q        <= '0;
				end
			end
			S_TE: begin
				if (!(mnode_q != '0 && g_rd_q == '0) && g_rd_q == '0) res_seen_q <= run_q;
			end
			S_TM: begin
				res_nm_q   <= m_rd_q;
				res_seen_q <= run_q | m_rd_q;
			end
			S_T0: if (!built_q) res_unb_q <= 1'b1;
			S_B_R1, S_B_M2: c_q <= c_q + 8'd1;
			S_B_UF: begin
				fu_q <= f_rd_q;
				c_q  <= '0;
			end
			S_B_U: u_q <= b_rd_q;
			S_B_C1: begin
				v_q    <= g_rd_q;
				node_q <= fu_q;
				if (g_rd_q == '0) c_q <= c_q + 8'd1;
			end
			S_B_W2: node_q <= f_rd_q;
			S_B_M1: mt_q <= m_rd_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			cnt_q    <= '0;
			emit_q   <= 1'b0;
			ncount_q <= (NODE_W+1)'(1);
			cur_q    <= '0;
			built_q  <= 1'b1;
			ov_q     <= 1'b0;
			mnode_q  <= '0;
			run_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + GOTO_AW'(1);
					if (cnt_q == '1) state_q <= emit_q ? S_OUT : S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_cmd.kind)
							K_CLR: begin
								state_q  <= S_CLR;
								cnt_q    <= '0;
								emit_q   <= 1'b1;
								ncount_q <= (NODE_W+1)'(1);
								cur_q    <= '0;
								built_q  <= 1'b1;
								ov_q     <= 1'b0;
								mnode_q  <= '0;
								run_q    <= '0;
							end
							K_PAT: state_q <= S_PB_RD;
							K_END: state_q <= S_EP_RD;
							K_BLD: begin
								state_q <= S_B_R0;
								head_q  <= '0;
								tail_q  <= '0;
							end
							K_TXT:   state_q <= S_T0;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_PB_RD: state_q <= S_PB_EV;
				S_PB_EV: begin
					if (g_rd_q != '0) begin
						cur_q <= g_rd_q;
					end else if (!ncount_q[NODE_W]) begin
						cur_q    <= ncount_q[NODE_W-1:0];
						ncount_q <= ncount_q + (NODE_W+1)'(1);
					end else begin
						ov_q <= 1'b1;
					end
					built_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_EP_RD: state_q <= S_EP_WR;
				S_EP_WR: begin
					cur_q   <= '0;
					built_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_T0: begin
					if (!built_q) state_q <= S_OUT;
					else if (cmd_q.first) state_q <= S_T1;
					else state_q <= S_TG;
				end
				S_T1: begin
					mnode_q <= '0;
					run_q   <= m_rd_q;
					state_q <= S_TG;
				end
				S_TG: state_q <= S_TE;
				S_TE: begin
					if (mnode_q != '0 && g_rd_q == '0) begin
						state_q <= S_TF;
					end else if (g_rd_q != '0) begin
						mnode_q <= g_rd_q;
						state_q <= S_TM;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_TF: begin
					mnode_q <= f_rd_q;
					state_q <= S_TG;
				end
				S_TM: begin
					run_q   <= run_q | m_rd_q;
					state_q <= S_OUT;
				end
				S_OUT: if (out_free) state_q <= S_IDLE;
				S_B_R0: state_q <= S_B_R1;
				S_B_R1: begin
					if (g_rd_q != '0 && !tail_q[NODE_W]) tail_q <= tail_q + (NODE_W+1)'(1);
					state_q <= (c_q == '1) ? S_B_H : S_B_R0;
				end
				S_B_H: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + (NODE_W+1)'(1);
						state_q <= S_B_U;
					end else begin
						built_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_B_U:  state_q <= S_B_UF;
				S_B_UF: state_q <= S_B_C0;
				S_B_C0: state_q <= S_B_C1;
				S_B_C1: begin
					if (g_rd_q == '0) begin
						state_q <= (c_q == '1) ? S_B_H : S_B_C0;
					end else begin
						if (!tail_q[NODE_W]) tail_q <= tail_q + (NODE_W+1)'(1);
						state_q <= S_B_W0;
					end
				end
				S_B_W0: state_q <= S_B_W1;
				S_B_W1: state_q <= (node_q != '0 && g_rd_q == '0) ? S_B_W2 : S_B_M1;
				S_B_W2: state_q <= S_B_W0;
				S_B_M1: state_q <= S_B_M2;
				S_B_M2: state_q <= (c_q == '1) ? S_B_H : S_B_C0;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register, loaded when the previous beat has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			status      <= res_unb_q ? ST_UNBUILT : (ov_q ? ST_OVF : ST_OK);
			node_mask   <= res_nm_q;
			seen_mask   <= res_seen_q;
			any_match   <= (res_seen_q != '0);
			end_of_text <= res_eot_q;
		end
	end

endmodule

### rtl/core/multi_pattern_substring_matcher.sv
// top level of the Aho-Corasick multi-pattern matcher
// instantiates mpsm_front and mpsm_back; depends on mpsm_pkg
//
//  channel   handshake                  payload
//  item      item_valid / item_stall    func data_byte pattern_slot first last
//  result    result_valid / result_stall status node_mask seen_mask any_match end_of_text
//
// a text byte reads the goto edge at its node, again after each failure-link hop, then
// the mask of the node reached; bounded by the goto read port; a pattern byte reads then
// writes goto, end pattern the mask; build scans every byte value at the root and at each
// queued node, then walks the fall-back hops and merges the mask for each child
// after reset and on a clear item the goto memory is swept; the back end takes no items
// then, and a two-entry queue takes up to two items before it raises item_stall
module multi_pattern_substring_matcher import mpsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [2:0]        func,
	input  logic [7:0]        data_byte,
	input  logic [4:0]        pattern_slot,
	input  logic              first,
	input  logic              last,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [1:0]        status,
	output logic [MASK_W-1:0] node_mask,
	output logic [MASK_W-1:0] seen_mask,
	output logic              any_match,
	output logic              end_of_text
);

	logic q_valid, q_pop;
	cmd_t q_cmd;

	mpsm_front u_front (
		.clk, .arst_n, .item_valid, .item_stall, .func, .data_byte, .pattern_slot,
		.first, .last, .q_valid, .q_cmd, .q_pop
	);

	mpsm_back u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_pop, .result_valid, .result_stall,
		.status, .node_mask, .seen_mask, .any_match, .end_of_text
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status != 2'd3) else $error("bad status code");

	a_unbuilt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_UNBUILT |-> node_mask == '0 && seen_mask == '0)
		else $error("unbuilt result carries masks");

	a_any_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> any_match == (seen_mask != '0)) else $error("any_match mismatch");

	a_node_in_seen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (node_mask & ~seen_mask) == '0) else $error("node mask not in seen");

endmodule

### bench/multi_pattern_substring_matcher_test.sv
// testbench for the multi-pattern substring matcher: a queue-fed driver and a monitor
// checked against an in-bench trie predictor; depends on mpsm_pkg and the top level
`timescale 1ns / 1ps

module multi_pattern_substring_matcher_test;
	import mpsm_pkg::*;

	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct {
		logic [2:0] func;
		logic [7:0] data_byte;
		logic [4:0] pattern_slot;
		logic       first;
		logic       last;
	} beat_t;

	typedef struct {
		logic [1:0]        status;
		logic [MASK_W-1:0] node_mask;
		logic [MASK_W-1:0] seen_mask;
		logic              any_match;
		logic              end_of_text;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [2:0] func = FN_CLEAR;
	logic [7:0] data_byte = 8'd0;
	logic [4:0] pattern_slot = 5'd0;
	logic first = 1'b0;
	logic last = 1'b0;
	logic result_valid;
	logic result_stall = 1'b1;
	logic [1:0] status;
	logic [MASK_W-1:0] node_mask;
	logic [MASK_W-1:0] seen_mask;
	logic any_match;
	logic end_of_text;

	beat_t  pending[$];
	match_t expected_matches[$];
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	logic   beat_in = 1'b0;
	bit     want_hold = 1'b0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	int     errors = 0;
	int     cycles = 0;

	// predictor state
	bit [8:0]        trie[GOTO_DEPTH];
	bit [7:0]        fail_to[MAX_NODES];
	bit [MASK_W-1:0] slot_bits[MAX_NODES];
	int              nodes_used;
	bit [7:0]        cursor;
	bit              built;
	bit              overflowed;
	bit [7:0]        text_node;
	bit [MASK_W-1:0] text_mask;

	multi_pattern_substring_matcher uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .data_byte(data_byte), .pattern_slot(pattern_slot),
		.first(first), .last(last),
		.result_valid(result_valid), .result_stall(result_stall),
		.status(status), .node_mask(node_mask), .seen_mask(seen_mask),
		.any_match(any_match), .end_of_text(end_of_text)
	);

	always #5 clk = ~clk;

	function automatic void trie_clear();
		foreach (trie[i]) trie[i] = '0;
		foreach (fail_to[i]) fail_to[i] = '0;
		foreach (slot_bits[i]) slot_bits[i] = '0;
		nodes_used = 1;
		cursor = '0;
		built = 1'b1;
		overflowed = 1'b0;
		text_node = '0;
		text_mask = '0;
	endfunction

	// follow failure links until an edge for c exists or the root is reached
	function automatic int walk_back(int node, int c);
		int steps;
		steps = 0;
		while (node != 0 && trie[node * 256 + c] == 0 && steps < MAX_NODES) begin
			node = fail_to[node];
			steps++;
		end
		return node;
	endfunction

	function automatic void link_trie();
		int order[$];
		int u, v, f, t;
		fail_to[0] = '0;
		for (int c = 0; c < 256; c++) begin
			if (trie[c] != 0) begin
				fail_to[trie[c]] = '0;
				order.insert(order.size(), trie[c]);
			end
		end
		while (order.size() > 0) begin
			u = order.pop_front();
			for (int c = 0; c < 256; c++) begin
				v = trie[u * 256 + c];
				if (v == 0) continue;
				order.insert(order.size(), v);
				f = walk_back(fail_to[u], c);
				t = trie[f * 256 + c];
				fail_to[v] = t[7:0];
				slot_bits[v] |= slot_bits[t];
			end
		end
		built = 1'b1;
	endfunction

	function automatic match_t predict_match(beat_t b);
		match_t r;
		int n, e;
		bit [MASK_W-1:0] hit;
		r = '{default: '0};
		hit = '0;
		case (b.func)
			FN_CLEAR: trie_clear();
			FN_PAT: begin
				e = trie[cursor * 256 + b.data_byte];
				if (e != 0) begin
					cursor = e[7:0];
				end else if (nodes_used < MAX_NODES) begin
					trie[cursor * 256 + b.data_byte] = nodes_used[8:0];
					slot_bits[nodes_used] = '0;
					fail_to[nodes_used] = '0;
					cursor = nodes_used[7:0];
					nodes_used++;
				end else begin
					overflowed = 1'b1;
				end
				built = 1'b0;
			end
			FN_END: begin
				slot_bits[cursor] |= MASK_W'(1) << b.pattern_slot;
				cursor = '0;
				built = 1'b0;
			end
			FN_BUILD: link_trie();
			FN_TEXT: begin
				r.end_of_text = b.last;
				if (!built) begin
					r.status = ST_UNBUILT;
					return r;
				end
				if (b.first) begin
					text_node = '0;
					text_mask = slot_bits[0];
				end
				n = walk_back(text_node, b.data_byte);
				e = trie[n * 256 + b.data_byte];
				if (e != 0) begin
					n = e;
					hit = slot_bits[n];
				end
				text_node = n[7:0];
				text_mask |= hit;
				r.node_mask = hit;
				r.seen_mask = text_mask;
				r.any_match = text_mask != 0;
			end
			default: ;
		endcase
		r.status = overflowed ? ST_OVF : ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!item_valid || beat_in)) begin
			if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				func <= pending[0].func;
				data_byte <= pending[0].data_byte;
				pattern_slot <= pending[0].pattern_slot;
				first <= pending[0].first;
				last <= pending[0].last;
				void'(pending.pop_front());
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (want_hold && !hold_done && hold_left == 0) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		beat_t b;
		match_t w;
		beat_in <= item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall) begin
			b = '{func, data_byte, pattern_slot, first, last};
			expected_matches.insert(expected_matches.size(), predict_match(b));
		end
		if (arst_n && result_valid && !result_stall) begin
			if (expected_matches.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				w = expected_matches.pop_front();
				if (status !== w.status) report_mismatch("status", status, w.status);
				if (node_mask !== w.node_mask)
					report_mismatch("node_mask", node_mask, w.node_mask);
				if (seen_mask !== w.seen_mask)
					report_mismatch("seen_mask", seen_mask, w.seen_mask);
				if (any_match !== w.any_match)
					report_mismatch("any_match", any_match, w.any_match);
				if (end_of_text !== w.end_of_text)
					report_mismatch("end_of_text", end_of_text, w.end_of_text);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_matches.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic add_beat(input logic [2:0] f, input logic [7:0] b, input logic [4:0] s,
			input logic fi, input logic la);
		beat_t nb;
		nb = '{f, b, s, fi, la};
		pending.insert(pending.size(), nb);
	endtask

	task automatic add_text(input logic [7:0] alpha[3], input int len, input bit fresh);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			c = ($urandom_range(9) < 8) ? alpha[$urandom_range(2)] : 8'($urandom);
			add_beat(FN_TEXT, c, 5'($urandom), fresh && i == 0, i == len - 1);
		end
	endtask

	// a few short patterns over a small alphabet, sometimes a spare code or early text, then a build and some text
	task automatic add_session(input logic [7:0] alpha[3]);
		int npat;
		npat = $urandom_range(1, 3);
		for (int p = 0; p < npat; p++) begin
			for (int i = $urandom_range(1, 3); i > 0; i--)
				add_beat(FN_PAT, ($urandom_range(9) == 0) ? 8'($urandom)
					: alpha[$urandom_range(2)], 5'($urandom), 1'($urandom), 1'($urandom));
			add_beat(FN_END, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
		end
		case ($urandom_range(9))
			0: add_beat(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), 8'($urandom),
				5'($urandom), 1'($urandom), 1'($urandom));
			1: add_text(alpha, $urandom_range(1, 3), 1'b1);
			default: ;
		endcase
		add_beat(FN_BUILD, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
		for (int t = $urandom_range(1, 3); t > 0; t--)
			add_text(alpha, $urandom_range(2, 14), $urandom_range(5) != 0);
	endtask

	task automatic wait_drained();
		while (pending.size() > 0 || (item_valid && !beat_in) || expected_matches.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [7:0] alpha[3];
		int start_count;
		trie_clear();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pattern, extreme bytes and slots, unbuilt text, spare codes
		add_beat(FN_TEXT, 8'h00, 5'd0, 1'b1, 1'b1);
		add_beat(FN_END, 8'h00, 5'd31, 1'b0, 1'b0);
		add_beat(FN_PAT, 8'h00, 5'd0, 1'b0, 1'b0);
		add_beat(FN_PAT, 8'hff, 5'd31, 1'b1, 1'b1);
		add_beat(FN_END, 8'hff, 5'd0, 1'b1, 1'b1);
		add_beat(FN_PAT, 8'hff, 5'd0, 1'b0, 1'b0);
		add_beat(FN_END, 8'h00, 5'd7, 1'b0, 1'b0);
		add_beat(FN_TEXT, 8'hff, 5'd0, 1'b1, 1'b0);
		add_beat(3'd5, 8'haa, 5'd10, 1'b1, 1'b0);
		add_beat(3'd6, 8'h55, 5'd21, 1'b0, 1'b1);
		add_beat(3'd7, 8'hff, 5'd31, 1'b1, 1'b1);
		add_beat(FN_BUILD, 8'h00, 5'd0, 1'b0, 1'b0);
		add_beat(FN_TEXT, 8'hff, 5'd0, 1'b1, 1'b0);
		add_beat(FN_TEXT, 8'h00, 5'd0, 1'b0, 1'b0);
		add_beat(FN_TEXT, 8'hff, 5'd0, 1'b0, 1'b1);
		// continues after a last without first
		add_beat(FN_TEXT, 8'hff, 5'd0, 1'b0, 1'b0);
		add_beat(FN_TEXT, 8'h42, 5'd0, 1'b0, 1'b1);
		add_beat(FN_TEXT, 8'h42, 5'd0, 1'b1, 1'b1);
		add_beat(FN_CLEAR, 8'h00, 5'd0, 1'b0, 1'b0);

		// overflow: one long chain runs past the node table
		for (int i = 0; i < MAX_NODES + 2; i++)
			add_beat(FN_PAT, 8'(i), 5'd0, 1'b0, 1'b0);
		add_beat(FN_END, 8'h00, 5'd3, 1'b0, 1'b0);
		add_beat(FN_TEXT, 8'h00, 5'd0, 1'b1, 1'b1);
		add_beat(FN_BUILD, 8'h00, 5'd0, 1'b0, 1'b0);
		for (int i = 0; i < 6; i++)
			add_beat(FN_TEXT, 8'(i), 5'd0, i == 0, i == 5);
		add_beat(FN_PAT, 8'h01, 5'd0, 1'b0, 1'b0);
		add_beat(FN_CLEAR, 8'h00, 5'd0, 1'b0, 1'b0);
		add_beat(FN_TEXT, 8'h00, 5'd0, 1'b1, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 83 : 0;
			recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 25 : 0;
			if (phase == 2) want_hold = 1'b1;
			foreach (alpha[i]) alpha[i] = 8'($urandom);
			start_count = pending.size();
			while (pending.size() - start_count < 100) begin
				add_session(alpha);
				if ($urandom_range(5) == 0) foreach (alpha[i]) alpha[i] = 8'($urandom);
			end
			add_beat(FN_CLEAR, 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
			wait_drained();
		end

		repeat (300) @(posedge clk);
		if (errors == 0 && expected_matches.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
